// File: rtl/pwmv_pkg.sv
// Package for the PWM tone setup block with volume control.
// Shared constants, prescale codes, controller state and command/status types.
// No dependencies.
package pwmv_pkg;

  // Field widths
  localparam int unsigned ClockW  = 28;
  localparam int unsigned FreqW   = 16;
  localparam int unsigned KnobW   = 12;
  localparam int unsigned TopW    = 16;
  localparam int unsigned PreW    = 2;

  // Serial divider: 32-bit dividend, 16-bit divisor, one quotient bit per step
  localparam int unsigned DivDvdW  = 32;
  localparam int unsigned DivSteps = DivDvdW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Reset value of the clock frequency register
  localparam logic [ClockW-1:0] ClockHzRst = ClockW'(150000000);

  // Largest wrap value
  localparam logic [TopW-1:0] TopMax = '1;

  // Volume average: new = (old * 9 * 4095 + sample * 65536) / (10 * 4095)
  localparam logic [15:0] VolMul = 16'd36855;
  // Divide by 40950 for any 32-bit n: floor(n/40950) = (floor(n/2) * VolRecip) >> 46
  localparam logic [31:0] VolRecip = 32'd3436812903;

  // Prescale codes
  localparam logic [PreW-1:0] PreDiv1   = 2'd0;
  localparam logic [PreW-1:0] PreDiv16  = 2'd1;
  localparam logic [PreW-1:0] PreDiv128 = 2'd2;

  // Request kinds
  localparam logic ReqTone   = 1'b0;
  localparam logic ReqVolume = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    CtlIdle,
    CtlDivide,
    CtlFinish
  } ctl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture request, start divider
    logic step;    // one divider step
    logic finish;  // commit state, load result register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic needs_div;  // request on the input needs a division
    logic div_last;   // divider is on its final step
    logic out_free;   // result register can take a new result
  } ctl_sts_t;

endpackage

// File: rtl/pwmv_req_if.sv
// Request channel interface: valid/ready plus request payload.
// Depends on nothing.
interface pwmv_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] tone_freq;
  logic [11:0] knob_sample;

  modport source (output valid, req_type, tone_freq, knob_sample, input ready);
  modport sink   (input valid, req_type, tone_freq, knob_sample, output ready);
endinterface

// File: rtl/pwmv_res_if.sv
// Result channel interface: valid/ready plus PWM setup payload.
// Depends on nothing.
interface pwmv_res_if;
  logic        valid;
  logic        ready;
  logic        tone_enabled;
  logic [1:0]  prescale_select;
  logic [15:0] wrap_top;
  logic [15:0] duty_level;
  logic        level_written;

  modport source (output valid, tone_enabled, prescale_select, wrap_top, duty_level,
                  level_written, input ready);
  modport sink   (input valid, tone_enabled, prescale_select, wrap_top, duty_level,
                  level_written, output ready);
endinterface

// File: rtl/pwmv_dp.sv
// Datapath: clock register, tone/volume state, serial divider, result register.
// Depends on pwmv_pkg; driven by pwmv_ctrl through ctl_cmd_t.
module pwmv_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pwmv_pkg::ClockW-1:0]   cfg_wdata_i,
  input  logic                          req_type_i,
  input  logic [pwmv_pkg::FreqW-1:0]    tone_freq_i,
  input  logic [pwmv_pkg::KnobW-1:0]    knob_sample_i,
  input  pwmv_pkg::ctl_cmd_t            cmd_i,
  output pwmv_pkg::ctl_sts_t            sts_o,
  input  logic                          res_ready_i,
  output logic                          res_valid_o,
  output logic                          tone_enabled_o,
  output logic [pwmv_pkg::PreW-1:0]     prescale_select_o,
  output logic [pwmv_pkg::TopW-1:0]     wrap_top_o,
  output logic [pwmv_pkg::TopW-1:0]     duty_level_o,
  output logic                          level_written_o
);
  import pwmv_pkg::*;

  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivSteps - 1);

  // Configuration and persistent state
  logic [ClockW-1:0] clock_hz_q;
  logic [TopW-1:0]   period_q, period_d;
  logic [15:0]       smooth_q, smooth_d;
  logic [PreW-1:0]   prescale_q, prescale_d;

  // Captured request
  logic kind_q;
  logic work_q;

  // Divider
  logic [DivDvdW-1:0] dvd_q, dvd_d;
  logic [15:0]        rem_q, rem_d;
  logic [15:0]        dsr_q, dsr_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;

  // Result register
  logic            out_valid_q, out_valid_d;
  logic            out_en_q, out_en_d;
  logic [PreW-1:0] out_pre_q, out_pre_d;
  logic [TopW-1:0] out_top_q, out_top_d;
  logic [TopW-1:0] out_lvl_q, out_lvl_d;
  logic            out_wr_q, out_wr_d;

  // Combinational helpers
  logic              needs_div;
  logic [31:0]       vol_num;
  logic [62:0]       recip_prod;
  logic [16:0]       trial;
  logic [16:0]       diff;
  logic              ge;
  logic [ClockW-1:0] count;
  logic [ClockW-1:0] count_m1;
  logic [23:0]       top16;
  logic [20:0]       top128;
  logic [PreW-1:0]   tone_pre;
  logic [TopW-1:0]   tone_top;
  logic [15:0]       avg;
  logic [30:0]       vol_prod;

  // Status to controller; the volume divide finishes in one step
  assign needs_div = (req_type_i == ReqVolume) ? (period_q != '0) : (tone_freq_i != '0);
  assign sts_o.needs_div = needs_div;
  assign sts_o.div_last  = (kind_q == ReqVolume) || (cnt_q == DivLast);
  assign sts_o.out_free  = !out_valid_q || res_ready_i;

  // Volume numerator: old * 9 * 4095 + sample * 65536, fits in 32 bits
  assign vol_num = {16'b0, smooth_q} * {16'b0, VolMul}
                 + {4'b0, knob_sample_i, 16'b0};

  // Volume numerator / 40950 by reciprocal multiply; quotient in bits 62:46
  assign recip_prod = dvd_q[DivDvdW-1:1] * VolRecip;

  // Restoring divider step
  assign trial = {rem_q, dvd_q[DivDvdW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = (trial >= {1'b0, dsr_q});

  // Tone period and prescale from count = clock_hz / freq
  assign count    = dvd_q[ClockW-1:0];
  assign count_m1 = count - ClockW'(1);
  assign top16    = count[ClockW-1:4] - 24'd1;
  assign top128   = count[ClockW-1:7] - 21'd1;

  always_comb begin
    if (count < ClockW'(TopMax)) begin
      tone_pre = PreDiv1;
      tone_top = (count == '0) ? '0 : count_m1[TopW-1:0];
    end else if (top16[23:16] != '0) begin
      tone_pre = PreDiv128;
      tone_top = (top128[20:16] != '0) ? TopMax : top128[15:0];
    end else begin
      tone_pre = PreDiv16;
      tone_top = top16[15:0];
    end
  end

  // Volume average saturation and level scaling
  assign avg      = (dvd_q[31:16] != '0) ? 16'hFFFF : dvd_q[15:0];
  assign vol_prod = period_q[TopW-1:1] * avg;

  // Divider next state
  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    dsr_d = dsr_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      rem_d = '0;
      cnt_d = '0;
      if (req_type_i == ReqVolume) begin
        dvd_d = vol_num;
      end else begin
        dvd_d = {{(DivDvdW-ClockW){1'b0}}, clock_hz_q};
        dsr_d = tone_freq_i;
      end
    end else if (cmd_i.step) begin
      cnt_d = cnt_q + DivCntW'(1);
      if (kind_q == ReqVolume) begin
        dvd_d = {15'b0, recip_prod[62:46]};
      end else begin
        rem_d = ge ? diff[15:0] : trial[15:0];
        dvd_d = {dvd_q[DivDvdW-2:0], ge};
      end
    end
  end

  // Commit state and build the result
  always_comb begin
    period_d    = period_q;
    smooth_d    = smooth_q;
    prescale_d  = prescale_q;
    out_en_d    = out_en_q;
    out_pre_d   = out_pre_q;
    out_top_d   = out_top_q;
    out_lvl_d   = out_lvl_q;
    out_wr_d    = out_wr_q;
    out_valid_d = out_valid_q && !res_ready_i;
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
      out_en_d    = 1'b0;
      out_pre_d   = prescale_q;
      out_top_d   = '0;
      out_lvl_d   = '0;
      out_wr_d    = 1'b0;
      if (kind_q == ReqTone) begin
        if (work_q) begin
          prescale_d = tone_pre;
          period_d   = tone_top;
          out_pre_d  = tone_pre;
          out_en_d   = 1'b1;
          out_top_d  = tone_top;
          out_lvl_d  = {1'b0, tone_top[TopW-1:1]};
          out_wr_d   = 1'b1;
        end else begin
          // tone stop
          period_d = '0;
        end
      end else if (work_q) begin
        smooth_d  = avg;
        out_en_d  = 1'b1;
        out_top_d = period_q;
        out_lvl_d = {1'b0, vol_prod[30:16]};
        out_wr_d  = 1'b1;
      end
    end
  end

  // Control and persistent state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q  <= ClockHzRst;
      period_q    <= '0;
      smooth_q    <= '0;
      prescale_q  <= PreDiv1;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        clock_hz_q <= cfg_wdata_i;
      end
      period_q    <= period_d;
      smooth_q    <= smooth_d;
      prescale_q  <= prescale_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= req_type_i;
      work_q <= needs_div;
    end
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    dsr_q     <= dsr_d;
    out_en_q  <= out_en_d;
    out_pre_q <= out_pre_d;
    out_top_q <= out_top_d;
    out_lvl_q <= out_lvl_d;
    out_wr_q  <= out_wr_d;
  end

  assign res_valid_o       = out_valid_q;
  assign tone_enabled_o    = out_en_q;
  assign prescale_select_o = out_pre_q;
  assign wrap_top_o        = out_top_q;
  assign duty_level_o      = out_lvl_q;
  assign level_written_o   = out_wr_q;

endmodule

// File: rtl/pwmv_ctrl.sv
// Controller state machine: accept, run the serial divider, commit the result.
// Depends on pwmv_pkg; drives pwmv_dp through ctl_cmd_t.
module pwmv_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  pwmv_pkg::ctl_sts_t  sts_i,
  output pwmv_pkg::ctl_cmd_t  cmd_o
);
  import pwmv_pkg::*;

  ctl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CtlIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      CtlIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.needs_div ? CtlDivide : CtlFinish;
        end
      end
      CtlDivide: begin
        cmd_o.step = 1'b1;
        if (sts_i.div_last) begin
          state_d = CtlFinish;
        end
      end
      CtlFinish: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = CtlIdle;
        end
      end
      default: begin
        state_d = CtlIdle;
      end
    endcase
  end

endmodule

// File: rtl/pwm_tone_setup_with_volume_core.sv
// Top level of the PWM tone setup block with volume control.
// Depends on pwmv_pkg, pwmv_req_if, pwmv_res_if, pwmv_ctrl and pwmv_dp.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+---------------------------------------------
//   req_i    | in  | valid/ready        | req_type, tone_freq, knob_sample
//   res_o    | out | valid/ready        | tone_enabled, prescale_select, wrap_top,
//            |     |                    |   duty_level, level_written
//   cfg      | in  | cfg_we_i, no ready | clock_hz (28 bits)
//
// A tone start is captured, runs 32 steps of the bit-serial divider, then commits. A
// volume sample with a tone running is captured, takes one reciprocal multiply step
// for the divide by 40950, then commits.
// A tone stop or a volume sample with no tone skips the divider: capture, then commit.
// One request is in flight at a time; a waiting result does not block the next
// transfer, but the commit of the following result waits for res_o to drain.
// Reset (asynchronous, active low) sets clock_hz to 150 MHz and clears all tone state.
module pwm_tone_setup_with_volume_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pwmv_pkg::ClockW-1:0]  cfg_wdata_i,
  pwmv_req_if.sink                     req_i,
  pwmv_res_if.source                   res_o
);
  import pwmv_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Sequencer
  pwmv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Divider, state and result register
  pwmv_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .req_type_i        (req_i.req_type),
    .tone_freq_i       (req_i.tone_freq),
    .knob_sample_i     (req_i.knob_sample),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .res_ready_i       (res_o.ready),
    .res_valid_o       (res_o.valid),
    .tone_enabled_o    (res_o.tone_enabled),
    .prescale_select_o (res_o.prescale_select),
    .wrap_top_o        (res_o.wrap_top),
    .duty_level_o      (res_o.duty_level),
    .level_written_o   (res_o.level_written)
  );

endmodule

// File: rtl/pwmv_checker.sv
// Port-level checker for the PWM tone setup block, with its bind statement.
// Depends on pwm_tone_setup_with_volume_core and its interface ports.
module pwmv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic        tone_enabled_i,
  input logic [1:0]  prescale_select_i,
  input logic [15:0] wrap_top_i,
  input logic [15:0] duty_level_i,
  input logic        level_written_i
);

  // A pending result stays offered
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped before transfer");

  // A running tone always carries a new duty level, a stopped one never does
  a_wr_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (level_written_i == tone_enabled_i))
    else $error("level_written disagrees with tone_enabled");

  // Stopped tone reports zero period and zero level
  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !tone_enabled_i |-> (wrap_top_i == '0) && (duty_level_i == '0))
    else $error("stopped tone with nonzero period or level");

  // Duty level never exceeds the wrap value
  a_lvl_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (duty_level_i <= wrap_top_i))
    else $error("duty level above wrap value");

  // Only three prescale codes exist
  a_pre_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (prescale_select_i != 2'd3))
    else $error("unused prescale code");

endmodule

bind pwm_tone_setup_with_volume_core pwmv_checker u_pwmv_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .res_valid_i       (res_o.valid),
  .res_ready_i       (res_o.ready),
  .tone_enabled_i    (res_o.tone_enabled),
  .prescale_select_i (res_o.prescale_select),
  .wrap_top_i        (res_o.wrap_top),
  .duty_level_i      (res_o.duty_level),
  .level_written_i   (res_o.level_written)
);

// File: tb/sv/tb_pwm_tone_setup_with_volume_core.sv
// Self-checking bench for pwm_tone_setup_with_volume_core: a directed stimulus table,
// then random tone and volume traffic under several clock settings.
// Depends on pwmv_pkg, pwmv_req_if, pwmv_res_if and the core RTL.
module tb_pwm_tone_setup_with_volume_core;
  import pwmv_pkg::*;

  localparam int unsigned KnobFullScale = 4095;
  localparam int unsigned AvgKeep       = 9;
  localparam int unsigned AvgDivisor    = 10 * KnobFullScale;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned NumPhases     = 7;
  localparam int unsigned MaxReports    = 10;

  typedef struct packed {
    logic             req_type;
    logic [FreqW-1:0] freq;
    logic [KnobW-1:0] knob;
  } tone_req_t;

  typedef struct packed {
    logic            tone_on;
    logic [PreW-1:0] prescale;
    logic [TopW-1:0] wrap;
    logic [TopW-1:0] duty;
    logic            level_wr;
  } pwm_setup_t;

  typedef struct packed {
    logic [ClockW-1:0] clock_hz;
    tone_req_t         rq;
    logic              typed;
    pwm_setup_t        want;
  } stim_row_t;

  // Results that can be read straight off the spec
  localparam pwm_setup_t NoSetup    = '0;
  localparam pwm_setup_t SatSetup   = '{1'b1, PreDiv128, TopMax, TopMax >> 1, 1'b1};
  localparam pwm_setup_t ZeroPeriod = '{1'b1, PreDiv1, 16'd0, 16'd0, 1'b1};
  localparam pwm_setup_t StoppedP16 = '{1'b0, PreDiv16, 16'd0, 16'd0, 1'b0};

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [ClockW-1:0] cfg_wdata_i;

  pwmv_req_if req_if ();
  pwmv_res_if res_if ();

  pwm_tone_setup_with_volume_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted block state
  logic [ClockW-1:0] pred_clock_hz;
  logic [TopW-1:0]   pred_period;
  logic [15:0]       pred_volume;
  logic [PreW-1:0]   pred_prescale;

  pwm_setup_t  pending_setups[$];
  int unsigned results_seen;
  int unsigned mismatch_count;
  int unsigned burst_left;

  // Coverage tallies for the summary
  int unsigned reqs_sent, tone_starts, saturated, zero_periods, tone_stops;
  int unsigned volume_updates, idle_volumes, clock_settings;

  // Divide the clock by the tone, or fold a knob sample into the running average
  function automatic pwm_setup_t predict_setup(input tone_req_t rq);
    pwm_setup_t      s;
    logic [31:0]     count, top, clk32, f32;
    logic [63:0]     num, avg;
    logic [PreW-1:0] pre;
    s     = NoSetup;
    clk32 = 32'(pred_clock_hz);
    f32   = 32'(rq.freq);
    if (rq.req_type == ReqTone) begin
      if (rq.freq == '0) begin
        pred_period = '0;
      end else begin
        count = clk32 / f32;
        if (count < 32'(TopMax)) begin
          pre = PreDiv1;
          top = (count == 0) ? 32'd0 : count - 1;
        end else begin
          pre = PreDiv16;
          top = clk32 / (f32 * 16) - 1;
          if (top > 32'(TopMax)) begin
            pre = PreDiv128;
            top = clk32 / (f32 * 128) - 1;
            if (top > 32'(TopMax)) top = 32'(TopMax);
          end
        end
        pred_prescale = pre;
        pred_period   = top[TopW-1:0];
        s.tone_on  = 1'b1;
        s.wrap     = pred_period;
        s.duty     = pred_period >> 1;
        s.level_wr = 1'b1;
      end
    end else if (pred_period != '0) begin
      num = 64'(AvgKeep) * 64'(pred_volume) * 64'(KnobFullScale) + 64'(rq.knob) * 64'd65536;
      avg = num / 64'(AvgDivisor);
      if (avg > 64'(TopMax)) avg = 64'(TopMax);
      pred_volume = avg[15:0];
      s.tone_on  = 1'b1;
      s.wrap     = pred_period;
      s.duty     = 16'((64'(pred_period >> 1) * 64'(pred_volume)) >> 16);
      s.level_wr = 1'b1;
    end
    s.prescale = pred_prescale;
    return s;
  endfunction

  function automatic stim_row_t mk_row(input logic [ClockW-1:0] clock_hz, input logic kind,
                                       input int unsigned freq, input int unsigned knob,
                                       input logic typed, input pwm_setup_t want);
    stim_row_t r;
    r.clock_hz    = clock_hz;
    r.rq.req_type = kind;
    r.rq.freq     = FreqW'(freq);
    r.rq.knob     = KnobW'(knob);
    r.typed       = typed;
    r.want        = want;
    return r;
  endfunction

  // Mostly volume samples behind tone starts; some stops and prescale-boundary tones
  function automatic tone_req_t rand_req();
    tone_req_t   r;
    int unsigned pick;
    logic [31:0] edge_f;
    r.req_type = ReqVolume;
    r.freq     = FreqW'($urandom);
    r.knob     = KnobW'($urandom);
    pick       = $urandom_range(0, 99);
    if (pick < 18) begin
      r.req_type = ReqTone;
      case ($urandom_range(0, 4))
        0: r.freq = FreqW'($urandom_range(1, 300));
        1: r.freq = FreqW'($urandom_range(1, 4000));
        2: begin
          edge_f = 32'(pred_clock_hz) / 32'(TopMax) + $urandom_range(0, 2);
          r.freq = (edge_f <= 1) ? FreqW'(1) : FreqW'(edge_f - 1);
        end
        3: begin
          edge_f = 32'(pred_clock_hz) / (32'(TopMax) * 16) + $urandom_range(0, 2);
          r.freq = (edge_f <= 1) ? FreqW'(1) : FreqW'(edge_f - 1);
        end
        default: ;
      endcase
    end else if (pick < 22) begin
      r.req_type = ReqTone;
      r.freq     = '0;
    end else if (pick >= 94) begin
      r.knob = pick[0] ? KnobW'(KnobFullScale) : '0;
    end
    return r;
  endfunction

  // Offer one request in bursts with random gaps; predict at the transfer
  task automatic send_req(input tone_req_t rq, input logic typed, input pwm_setup_t want);
    int unsigned gap;
    pwm_setup_t  pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    req_if.valid       <= 1'b1;
    req_if.req_type    <= rq.req_type;
    req_if.tone_freq   <= rq.freq;
    req_if.knob_sample <= rq.knob;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pred = predict_setup(rq);
    pending_setups.push_back(typed ? want : pred);
    reqs_sent++;
    if (rq.req_type == ReqTone && rq.freq == '0) tone_stops++;
    else if (rq.req_type == ReqTone) begin
      tone_starts++;
      if (pred.wrap == TopMax) saturated++;
      if (pred.wrap == '0) zero_periods++;
    end else if (pred.level_wr) volume_updates++;
    else idle_volumes++;
    @(negedge clk_i);
  endtask

  // Stop offering and let every pending result drain
  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    while (pending_setups.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_clock(input logic [ClockW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    pred_clock_hz = value;
    clock_settings++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Result checker: every transfer on res_o against the oldest prediction
  always @(posedge clk_i) begin : result_check
    pwm_setup_t got, want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = '{res_if.tone_enabled, res_if.prescale_select, res_if.wrap_top,
              res_if.duty_level, res_if.level_written};
      results_seen++;
      if (pending_setups.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("ERROR: result with none pending: on=%0d pre=%0d top=%0d duty=%0d wr=%0d",
                   got.tone_on, got.prescale, got.wrap, got.duty, got.level_wr);
      end else begin
        want = pending_setups.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display({"ERROR: result %0d: exp on=%0d pre=%0d top=%0d duty=%0d wr=%0d,",
                      " got on=%0d pre=%0d top=%0d duty=%0d wr=%0d"}, results_seen,
                     want.tone_on, want.prescale, want.wrap, want.duty, want.level_wr,
                     got.tone_on, got.prescale, got.wrap, got.duty, got.level_wr);
        end
      end
    end
  end

  // Result side ready: segments of random stall modes, plus two long hold-offs
  initial begin : result_ready
    int unsigned mode, span, hold_idx;
    logic [7:0]  stall_pat;
    int unsigned hold_at [2];
    hold_at[0] = 400;
    hold_at[1] = 1300;
    hold_idx   = 0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      mode      = $urandom_range(0, 3);
      span      = $urandom_range(20, 200);
      stall_pat = 8'($urandom) | 8'h01;
      repeat (span) begin
        @(negedge clk_i);
        if (hold_idx < 2 && results_seen >= hold_at[hold_idx]) begin
          res_if.ready <= 1'b0;
          repeat (LongHold - 1) @(negedge clk_i);
          hold_idx++;
        end else begin
          case (mode)
            0: res_if.ready <= 1'b1;
            1: res_if.ready <= ($urandom_range(0, 9) < 7);
            2: begin
              res_if.ready <= stall_pat[0];
              stall_pat = {stall_pat[0], stall_pat[7:1]};
            end
            default: res_if.ready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  // Main stimulus
  initial begin : stimulus
    stim_row_t         rows[$];
    tone_req_t         rq;
    logic              paused;
    int unsigned       counted;
    logic [ClockW-1:0] phase_clock [NumPhases];
    int unsigned       phase_items [NumPhases];

    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    req_if.valid       <= 1'b0;
    req_if.req_type    <= ReqTone;
    req_if.tone_freq   <= '0;
    req_if.knob_sample <= '0;
    pred_clock_hz  = ClockHzRst;
    pred_period    = '0;
    pred_volume    = '0;
    pred_prescale  = PreDiv1;
    results_seen   = 0;
    mismatch_count = 0;
    burst_left     = 0;
    paused         = 1'b0;

    // At reset clock: idle volume, stop, saturated period, average, prescale edges
    rows.push_back(mk_row(ClockHzRst, ReqVolume, 0, 4095, 1'b1, NoSetup));
    rows.push_back(mk_row(ClockHzRst, ReqTone, 0, 0, 1'b1, NoSetup));
    rows.push_back(mk_row(ClockHzRst, ReqTone, 1, 0, 1'b1, SatSetup));
    rows.push_back(mk_row(ClockHzRst, ReqVolume, 0, 4095, 1'b0, NoSetup));
    rows.push_back(mk_row(ClockHzRst, ReqVolume, 0, 0, 1'b0, NoSetup));
    rows.push_back(mk_row(ClockHzRst, ReqVolume, 65535, 4095, 1'b0, NoSetup));
    rows.push_back(mk_row(ClockHzRst, ReqTone, 65535, 0, 1'b0, NoSetup));
    rows.push_back(mk_row(ClockHzRst, ReqVolume, 0, 2048, 1'b0, NoSetup));
    rows.push_back(mk_row(ClockHzRst, ReqTone, 2288, 0, 1'b0, NoSetup));
    rows.push_back(mk_row(ClockHzRst, ReqTone, 2289, 0, 1'b0, NoSetup));
    rows.push_back(mk_row(ClockHzRst, ReqTone, 143, 0, 1'b0, NoSetup));
    rows.push_back(mk_row(ClockHzRst, ReqTone, 144, 4095, 1'b0, NoSetup));
    rows.push_back(mk_row(ClockHzRst, ReqTone, 0, 0, 1'b1, StoppedP16));
    rows.push_back(mk_row(ClockHzRst, ReqVolume, 0, 4095, 1'b1, StoppedP16));
    // 1 MHz and 200 MHz clock settings
    rows.push_back(mk_row(28'd1_000_000, ReqTone, 1, 0, 1'b0, NoSetup));
    rows.push_back(mk_row(28'd1_000_000, ReqTone, 15, 0, 1'b0, NoSetup));
    rows.push_back(mk_row(28'd1_000_000, ReqVolume, 0, 4095, 1'b0, NoSetup));
    rows.push_back(mk_row(28'd200_000_000, ReqTone, 1, 0, 1'b1, SatSetup));
    rows.push_back(mk_row(28'd200_000_000, ReqVolume, 0, 4095, 1'b0, NoSetup));
    // Zero clock: zero period, later volume ignored; then the largest clock
    rows.push_back(mk_row('0, ReqTone, 1, 0, 1'b1, ZeroPeriod));
    rows.push_back(mk_row('0, ReqVolume, 0, 4095, 1'b1, NoSetup));
    rows.push_back(mk_row('1, ReqTone, 1, 0, 1'b1, SatSetup));
    rows.push_back(mk_row('1, ReqTone, 65535, 0, 1'b0, NoSetup));
    // Clock below and equal to the tone frequency
    rows.push_back(mk_row(28'd40_000, ReqTone, 65535, 0, 1'b1, ZeroPeriod));
    rows.push_back(mk_row(28'd40_000, ReqTone, 40000, 0, 1'b0, NoSetup));

    phase_clock[0] = 28'd1_000_000;     phase_items[0] = 290;
    phase_clock[1] = 28'd200_000_000;   phase_items[1] = 290;
    phase_clock[2] = '1;                phase_items[2] = 270;
    phase_clock[3] = '0;                phase_items[3] = 40;
    phase_clock[4] = 28'd40_000;        phase_items[4] = 200;
    phase_clock[5] = ClockW'($urandom_range(1_000_000, 200_000_000));
    phase_items[5] = 290;
    phase_clock[6] = ClockHzRst;        phase_items[6] = 345;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table; the clock register changes only with nothing in flight
    foreach (rows[i]) begin
      if (rows[i].clock_hz != pred_clock_hz) begin
        wait_for_results();
        write_clock(rows[i].clock_hz);
      end
      send_req(rows[i].rq, rows[i].typed, rows[i].want);
    end

    // Random phases, one clock setting each
    for (int p = 0; p < NumPhases; p++) begin
      wait_for_results();
      write_clock(phase_clock[p]);
      counted = 0;
      while (counted < phase_items[p]) begin
        rq = rand_req();
        send_req(rq, 1'b0, NoSetup);
        counted++;
        if (p == 0 && counted == 120 && !paused) begin
          wait_for_results();
          paused = 1'b1;
        end
      end
    end

    wait_for_results();
    repeat (40) @(posedge clk_i);
    if (pending_setups.size() != 0) begin
      mismatch_count++;
      $display("ERROR: %0d results never arrived", pending_setups.size());
    end

    $display("Run covered %0d requests over %0d clock settings: %0d tone starts (%0d saturated,",
             reqs_sent, clock_settings + 1, tone_starts, saturated);
    $display("  %0d zero period), %0d stops, %0d volume updates, %0d idle samples; %0d errors",
             zero_periods, tone_stops, volume_updates, idle_volumes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("ERROR: timeout with %0d results pending", pending_setups.size());
    $display("Verification failed");
    $finish;
  end

endmodule

// File: pwm_tone_setup_with_volume_core.f
rtl/pwmv_pkg.sv
rtl/pwmv_req_if.sv
rtl/pwmv_res_if.sv
rtl/pwmv_dp.sv
rtl/pwmv_ctrl.sv
rtl/pwm_tone_setup_with_volume_core.sv
rtl/pwmv_checker.sv
tb/sv/tb_pwm_tone_setup_with_volume_core.sv
